[hdl/tlaik_pkg.sv]
// ----------------------------------------------------------------------------
// tlaik_pkg
// Shared types, constants and tables for the two-link arm inverse kinematics
// unit: controller commands, datapath status, CORDIC angle table, servo
// command rounding.
// ----------------------------------------------------------------------------
package tlaik_pkg;

  localparam int COORD_W   = 16;
  localparam int LINK_W    = 14;
  localparam int SVO_W     = 8;
  localparam int MUL_W     = 32;
  localparam int SQR_W     = 28;   // squared link length
  localparam int SUMSQ_W   = 30;   // squared link sum / difference
  localparam int R16_W     = 23;   // Q16 root of r^2 and ground distance
  localparam int CW        = 40;   // CORDIC and acos operand width
  localparam int ANG_W     = 26;   // Q16 degrees
  localparam int CMD_W     = 28;   // angle sums before rounding
  localparam int SQ_W      = 60;   // square root radicand
  localparam int ROOT_W    = 30;
  localparam int SQ_STEPS  = 30;
  localparam int SQ_CNT_W  = 5;
  localparam int FRAC_W    = 16;
  localparam int TAB_W     = 22;
  localparam int TAB_IDX_W = 5;
  localparam int CMDV_W    = 9;    // rounded, clamped command before halving

  localparam logic signed [ANG_W-1:0] ANG90      = 26'sd5898240;
  localparam logic signed [CMD_W-1:0] DEG90      = 28'sd5898240;
  localparam logic signed [CMD_W-1:0] DEG180     = 28'sd11796480;
  localparam logic signed [CMD_W-1:0] ROUND_HALF = 28'sd32768;
  localparam logic signed [CW-1:0]    NORM_LIMIT = 40'sd1073741824;

  localparam logic [LINK_W-1:0] UPPER_RESET = 14'd5120;
  localparam logic [LINK_W-1:0] LOWER_RESET = 14'd3840;
  localparam logic [SVO_W-1:0]  HELD_RESET  = 8'd90;
  localparam logic [CMDV_W-1:0] ANGLE_MAX   = 9'd180;
  localparam logic [CMDV_W-1:0] ELBOW_MAX   = 9'd360;

  localparam logic REG_UPPER = 1'b0;

  typedef enum logic [3:0] {
    MUL_XX, MUL_YY, MUL_ZZ, MUL_AA, MUL_BB, MUL_SUM, MUL_DIF, MUL_AR, MUL_AB,
    MUL_DD, MUL_NN
  } mul_sel_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_G2_SET, OP_G2_ADD, OP_R2_SET, OP_AA_SET, OP_BB_SET,
    OP_SUMSQ_SET, OP_DIFSQ_SET, OP_REACH, OP_R16_SET, OP_G16_SET, OP_BASE_SET,
    OP_BETA_SET, OP_GAMMA_LD, OP_ALPHA_LD, OP_CLAMP, OP_HALVE, OP_TMP_SET,
    OP_RAD_SET, OP_GAMMA_SET, OP_ALPHA_SET, OP_OUT_LOAD
  } op_t;

  typedef enum logic [1:0] {SQ_R2, SQ_G2, SQ_RAD} sq_sel_t;
  typedef enum logic [1:0] {CB_BASE, CB_BETA, CB_ACOS} cb_sel_t;

  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
    logic     sq_start;
    sq_sel_t  sq_sel;
    logic     cb_start;
    cb_sel_t  cb_sel;
  } cmd_t;

  typedef struct packed {
    logic reach;
    logic den_big;
    logic sq_done;
    logic cb_done;
  } status_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half away from zero to whole degrees, clamp to 0..hi
  function automatic logic [CMDV_W-1:0] servo_cmd(input logic signed [CMD_W-1:0] v,
                                                  input logic [CMDV_W-1:0] hi);
    logic signed [CMD_W-1:0] r;
    logic [CMDV_W-1:0] res;
    if (v >= 0) begin
      r = (v + ROUND_HALF) >>> FRAC_W;
    end else begin
      r = -((-v + ROUND_HALF) >>> FRAC_W);
    end
    if (r < 0) begin
      res = '0;
    end else if (r > $signed({{(CMD_W-CMDV_W){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = r[CMDV_W-1:0];
    end
    return res;
  endfunction

endpackage

[hdl/tlaik_sqrt.sv]
// ----------------------------------------------------------------------------
// tlaik_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tlaik_sqrt
  import tlaik_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic [SQ_CNT_W-1:0] LAST = SQ_CNT_W'(SQ_STEPS - 1);

  logic [SQ_W-1:0]     rem;
  logic [SQ_W-1:0]     res;
  logic [SQ_W-1:0]     bitv;
  logic [SQ_W-1:0]     trial;
  logic [SQ_CNT_W-1:0] cnt;
  logic                busy;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= TOP_BIT;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/tlaik_cordic.sv]
// ----------------------------------------------------------------------------
// tlaik_cordic
// Vectoring CORDIC atan2 in Q16 degrees, one rotation per cycle after a
// quarter-turn pre-rotation that makes x non-negative.
// ----------------------------------------------------------------------------
module tlaik_cordic
  import tlaik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CW-1:0]    x_in,
  input  logic signed [CW-1:0]    y_in,
  output logic signed [ANG_W-1:0] angle,
  output logic                    done
);

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic signed [CW-1:0]    cx;
  logic signed [CW-1:0]    cy;
  logic signed [CW-1:0]    dx;
  logic signed [CW-1:0]    dy;
  logic signed [ANG_W-1:0] da;

  assign dx    = cy >>> step;
  assign dy    = cx >>> step;
  assign da    = $signed(ANG_W'(atan_entry(TAB_IDX_W'(step))));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          // atan2(0, 0) is defined as zero
          angle <= '0;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              cx    <= y_in;
              cy    <= -x_in;
              angle <= ANG90;
            end else begin
              cx    <= -y_in;
              cy    <= x_in;
              angle <= -ANG90;
            end
          end else begin
            cx    <= x_in;
            cy    <= y_in;
            angle <= '0;
          end
        end
      end else if (busy) begin
        if (cy > 0) begin
          cx    <= cx + dx;
          cy    <= cy - dy;
          angle <= angle + da;
        end else begin
          cx    <= cx - dx;
          cy    <= cy + dy;
          angle <= angle - da;
        end
        step <= step + 1'b1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/tlaik_datapath.sv]
// ----------------------------------------------------------------------------
// tlaik_datapath
// Link registers, shared multiplier, working registers, square root and
// CORDIC units, held commands and the result register.
// ----------------------------------------------------------------------------
module tlaik_datapath
  import tlaik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16
)
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [COORD_W-1:0] target_x,
  input  logic [COORD_W-1:0] target_y,
  input  logic [COORD_W-1:0] target_z,
  input  logic               write_enable,
  input  logic               register_index,
  input  logic [LINK_W-1:0]  write_data,
  output logic               reachable,
  output logic [SVO_W-1:0]   base_command,
  output logic [SVO_W-1:0]   shoulder_command,
  output logic [SVO_W-1:0]   elbow_command
);

  localparam int CB_EFF = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int EXT_SH = COORD_W - CB_EFF;

  function automatic logic signed [COORD_W-1:0] coord_ext(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] t;
    t = $signed(raw << EXT_SH);
    return t >>> EXT_SH;
  endfunction

  logic [LINK_W-1:0]         upper_len;
  logic [LINK_W-1:0]         lower_len;
  logic signed [COORD_W-1:0] xs;
  logic signed [COORD_W-1:0] ys;
  logic signed [COORD_W-1:0] zs;
  logic [MUL_W-1:0]          g2;
  logic [MUL_W-1:0]          r2;
  logic [SQR_W-1:0]          aa;
  logic [SQR_W-1:0]          bb;
  logic [SUMSQ_W-1:0]        sumsq;
  logic [SUMSQ_W-1:0]        difsq;
  logic [R16_W-1:0]          r16;
  logic [R16_W-1:0]          g16;
  logic signed [CW-1:0]      num;
  logic signed [CW-1:0]      den;
  logic [SQ_W-1:0]           tmp;
  logic [SQ_W-1:0]           rad;
  logic signed [ANG_W-1:0]   base_ang;
  logic signed [ANG_W-1:0]   beta_ang;
  logic signed [ANG_W-1:0]   gamma_ang;
  logic signed [ANG_W-1:0]   alpha_ang;
  logic                      reach_ok;
  logic [2*MUL_W-1:0]        prod;
  logic [SVO_W-1:0]          held_base;
  logic [SVO_W-1:0]          held_shoulder;
  logic [SVO_W-1:0]          held_elbow;

  logic [COORD_W:0]          abs_x;
  logic [COORD_W:0]          abs_y;
  logic [COORD_W:0]          abs_z;
  logic [LINK_W:0]           link_sum;
  logic [LINK_W-1:0]         link_dif;
  logic signed [CW-1:0]      abs_num;
  logic signed [CW-1:0]      neg_den;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [2*MUL_W-1:0]        mul_p;
  logic signed [CW-1:0]      aa_w;
  logic signed [CW-1:0]      bb_w;
  logic signed [CW-1:0]      r2_w;
  logic signed [CW-1:0]      gamma_num;
  logic signed [CW-1:0]      alpha_num;
  logic [SQ_W-1:0]           sq_in;
  logic [ROOT_W-1:0]         sq_root;
  logic                      sq_done;
  logic signed [CW-1:0]      cb_x;
  logic signed [CW-1:0]      cb_y;
  logic signed [ANG_W-1:0]   cb_angle;
  logic                      cb_done;
  logic signed [CMD_W-1:0]   base_v;
  logic signed [CMD_W-1:0]   shoulder_v;
  logic signed [CMD_W-1:0]   elbow_v;
  logic [CMDV_W-1:0]         base_c;
  logic [CMDV_W-1:0]         shoulder_c;
  logic [CMDV_W-1:0]         elbow_c;

  assign abs_x = xs[COORD_W-1] ? (~{1'b1, xs} + 1'b1) : {1'b0, xs};
  assign abs_y = ys[COORD_W-1] ? (~{1'b1, ys} + 1'b1) : {1'b0, ys};
  assign abs_z = zs[COORD_W-1] ? (~{1'b1, zs} + 1'b1) : {1'b0, zs};
  assign link_sum = {1'b0, upper_len} + {1'b0, lower_len};
  assign link_dif = (upper_len >= lower_len) ? (upper_len - lower_len)
                                             : (lower_len - upper_len);
  assign abs_num = num[CW-1] ? -num : num;
  assign neg_den = -den;

  always_comb begin
    case (cmd.mul)
      MUL_XX:  begin mul_a = MUL_W'(abs_x);     mul_b = MUL_W'(abs_x);     end
      MUL_YY:  begin mul_a = MUL_W'(abs_y);     mul_b = MUL_W'(abs_y);     end
      MUL_ZZ:  begin mul_a = MUL_W'(abs_z);     mul_b = MUL_W'(abs_z);     end
      MUL_AA:  begin mul_a = MUL_W'(upper_len); mul_b = MUL_W'(upper_len); end
      MUL_BB:  begin mul_a = MUL_W'(lower_len); mul_b = MUL_W'(lower_len); end
      MUL_SUM: begin mul_a = MUL_W'(link_sum);  mul_b = MUL_W'(link_sum);  end
      MUL_DIF: begin mul_a = MUL_W'(link_dif);  mul_b = MUL_W'(link_dif);  end
      MUL_AR:  begin mul_a = MUL_W'(upper_len); mul_b = MUL_W'(r16);       end
      MUL_AB:  begin mul_a = MUL_W'(upper_len); mul_b = MUL_W'(lower_len); end
      MUL_DD:  begin mul_a = den[MUL_W-1:0];    mul_b = den[MUL_W-1:0];    end
      MUL_NN:  begin mul_a = abs_num[MUL_W-1:0]; mul_b = abs_num[MUL_W-1:0]; end
      default: begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // law of cosines numerators
  assign aa_w      = $signed(CW'(aa));
  assign bb_w      = $signed(CW'(bb));
  assign r2_w      = $signed(CW'(r2));
  assign gamma_num = (aa_w + r2_w - bb_w) <<< 8;
  assign alpha_num = aa_w + bb_w - r2_w;

  always_comb begin
    case (cmd.sq_sel)
      SQ_R2:   sq_in = SQ_W'({r2, 16'b0});
      SQ_G2:   sq_in = SQ_W'({g2, 16'b0});
      SQ_RAD:  sq_in = rad;
      default: sq_in = '0;
    endcase
  end

  always_comb begin
    case (cmd.cb_sel)
      CB_BASE: begin
        cb_y = CW'($signed({ys, 16'b0}));
        cb_x = CW'($signed({xs, 16'b0}));
      end
      CB_BETA: begin
        cb_y = CW'($signed({zs, 8'b0}));
        cb_x = $signed(CW'(g16));
      end
      CB_ACOS: begin
        cb_y = $signed(CW'(sq_root));
        cb_x = num;
      end
      default: begin
        cb_y = '0;
        cb_x = '0;
      end
    endcase
  end

  tlaik_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sq_start),
    .radicand (sq_in),
    .root     (sq_root),
    .done     (sq_done)
  );

  tlaik_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cb_start),
    .x_in  (cb_x),
    .y_in  (cb_y),
    .angle (cb_angle),
    .done  (cb_done)
  );

  assign status.reach   = !((r2 > MUL_W'(sumsq)) || (r2 < MUL_W'(difsq)));
  assign status.den_big = (den >= NORM_LIMIT);
  assign status.sq_done = sq_done;
  assign status.cb_done = cb_done;

  assign base_v     = CMD_W'(base_ang) + DEG90;
  assign shoulder_v = CMD_W'(beta_ang) - CMD_W'(gamma_ang) + DEG90;
  assign elbow_v    = DEG180 - CMD_W'(alpha_ang);
  assign base_c     = servo_cmd(base_v, ANGLE_MAX);
  assign shoulder_c = servo_cmd(shoulder_v, ANGLE_MAX);
  assign elbow_c    = servo_cmd(elbow_v, ELBOW_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len     <= UPPER_RESET;
      lower_len     <= LOWER_RESET;
      held_base     <= HELD_RESET;
      held_shoulder <= HELD_RESET;
      held_elbow    <= HELD_RESET;
    end else begin
      if (write_enable) begin
        if (register_index == REG_UPPER) begin
          upper_len <= write_data;
        end else begin
          lower_len <= write_data;
        end
      end
      if (cmd.op == OP_OUT_LOAD && reach_ok) begin
        held_base     <= base_c[SVO_W-1:0];
        held_shoulder <= shoulder_c[SVO_W-1:0];
        held_elbow    <= elbow_c[CMDV_W-1:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (cmd.op)
      OP_LOAD: begin
        xs <= coord_ext(target_x);
        ys <= coord_ext(target_y);
        zs <= coord_ext(target_z);
      end
      OP_G2_SET:    g2    <= prod[MUL_W-1:0];
      OP_G2_ADD:    g2    <= g2 + prod[MUL_W-1:0];
      OP_R2_SET:    r2    <= g2 + prod[MUL_W-1:0];
      OP_AA_SET:    aa    <= prod[SQR_W-1:0];
      OP_BB_SET:    bb    <= prod[SQR_W-1:0];
      OP_SUMSQ_SET: sumsq <= prod[SUMSQ_W-1:0];
      OP_DIFSQ_SET: difsq <= prod[SUMSQ_W-1:0];
      OP_REACH:     reach_ok <= status.reach;
      OP_R16_SET:   r16   <= sq_root[R16_W-1:0];
      OP_G16_SET:   g16   <= sq_root[R16_W-1:0];
      OP_BASE_SET:  base_ang <= cb_angle;
      OP_BETA_SET:  beta_ang <= cb_angle;
      OP_GAMMA_LD: begin
        num <= gamma_num;
        den <= $signed({prod[CW-2:0], 1'b0});
      end
      OP_ALPHA_LD: begin
        num <= alpha_num;
        den <= $signed({prod[CW-2:0], 1'b0});
      end
      OP_CLAMP: begin
        // cosine beyond plus or minus one
        if (num > den) begin
          num <= den;
        end else if (num < neg_den) begin
          num <= neg_den;
        end
      end
      OP_HALVE: begin
        num <= num >>> 1;
        den <= den >>> 1;
      end
      OP_TMP_SET:   tmp <= prod[SQ_W-1:0];
      OP_RAD_SET:   rad <= tmp - prod[SQ_W-1:0];
      OP_GAMMA_SET: gamma_ang <= cb_angle;
      OP_ALPHA_SET: alpha_ang <= cb_angle;
      OP_OUT_LOAD: begin
        reachable <= reach_ok;
        if (reach_ok) begin
          base_command     <= base_c[SVO_W-1:0];
          shoulder_command <= shoulder_c[SVO_W-1:0];
          elbow_command    <= elbow_c[CMDV_W-1:1];
        end else begin
          base_command     <= held_base;
          shoulder_command <= held_shoulder;
          elbow_command    <= held_elbow;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/tlaik_ctrl.sv]
// ----------------------------------------------------------------------------
// tlaik_ctrl
// Sequencer: steps the datapath through reach test, roots, atan2 and the
// two acos evaluations, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tlaik_ctrl
  import tlaik_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    target_valid,
  output logic    target_stall,
  output logic    result_valid,
  input  logic    result_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [4:0] {
    S_IDLE, S_MXX, S_MYY, S_MZZ, S_MAA, S_MBB, S_MSUM, S_MDIF, S_DIFW, S_REACH,
    S_SQR_GO, S_SQR_WAIT, S_SQG_GO, S_SQG_WAIT, S_CB_GO, S_CB_WAIT, S_CBT_GO,
    S_CBT_WAIT, S_GM_MUL, S_GM_LD, S_AL_MUL, S_AL_LD, S_AC_CLAMP, S_AC_NORM,
    S_AC_MDD, S_AC_MNN, S_AC_RAD, S_AC_SQ_GO, S_AC_SQ_WAIT, S_AC_CB_GO,
    S_AC_CB_WAIT, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   second;       // high during the elbow (alpha) acos pass
  logic   second_next;
  logic   load_out;

  assign target_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    second_next  = second;
    load_out     = 1'b0;
    cmd.mul      = MUL_XX;
    cmd.op       = OP_NONE;
    cmd.sq_start = 1'b0;
    cmd.sq_sel   = SQ_R2;
    cmd.cb_start = 1'b0;
    cmd.cb_sel   = CB_BASE;
    case (state)
      S_IDLE: begin
        if (target_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_MXX;
        end
      end
      S_MXX: begin
        cmd.mul    = MUL_XX;
        state_next = S_MYY;
      end
      S_MYY: begin
        cmd.mul    = MUL_YY;
        cmd.op     = OP_G2_SET;
        state_next = S_MZZ;
      end
      S_MZZ: begin
        cmd.mul    = MUL_ZZ;
        cmd.op     = OP_G2_ADD;
        state_next = S_MAA;
      end
      S_MAA: begin
        cmd.mul    = MUL_AA;
        cmd.op     = OP_R2_SET;
        state_next = S_MBB;
      end
      S_MBB: begin
        cmd.mul    = MUL_BB;
        cmd.op     = OP_AA_SET;
        state_next = S_MSUM;
      end
      S_MSUM: begin
        cmd.mul    = MUL_SUM;
        cmd.op     = OP_BB_SET;
        state_next = S_MDIF;
      end
      S_MDIF: begin
        cmd.mul    = MUL_DIF;
        cmd.op     = OP_SUMSQ_SET;
        state_next = S_DIFW;
      end
      S_DIFW: begin
        cmd.op     = OP_DIFSQ_SET;
        state_next = S_REACH;
      end
      S_REACH: begin
        cmd.op     = OP_REACH;
        state_next = status.reach ? S_SQR_GO : S_FINISH;
      end
      S_SQR_GO: begin
        cmd.sq_start = 1'b1;
        cmd.sq_sel   = SQ_R2;
        state_next   = S_SQR_WAIT;
      end
      S_SQR_WAIT: begin
        if (status.sq_done) begin
          cmd.op     = OP_R16_SET;
          state_next = S_SQG_GO;
        end
      end
      S_SQG_GO: begin
        cmd.sq_start = 1'b1;
        cmd.sq_sel   = SQ_G2;
        state_next   = S_SQG_WAIT;
      end
      S_SQG_WAIT: begin
        if (status.sq_done) begin
          cmd.op     = OP_G16_SET;
          state_next = S_CB_GO;
        end
      end
      S_CB_GO: begin
        cmd.cb_start = 1'b1;
        cmd.cb_sel   = CB_BASE;
        state_next   = S_CB_WAIT;
      end
      S_CB_WAIT: begin
        if (status.cb_done) begin
          cmd.op     = OP_BASE_SET;
          state_next = S_CBT_GO;
        end
      end
      S_CBT_GO: begin
        cmd.cb_start = 1'b1;
        cmd.cb_sel   = CB_BETA;
        state_next   = S_CBT_WAIT;
      end
      S_CBT_WAIT: begin
        if (status.cb_done) begin
          cmd.op     = OP_BETA_SET;
          state_next = S_GM_MUL;
        end
      end
      S_GM_MUL: begin
        cmd.mul     = MUL_AR;
        second_next = 1'b0;
        state_next  = S_GM_LD;
      end
      S_GM_LD: begin
        cmd.op     = OP_GAMMA_LD;
        state_next = S_AC_CLAMP;
      end
      S_AL_MUL: begin
        cmd.mul    = MUL_AB;
        state_next = S_AL_LD;
      end
      S_AL_LD: begin
        cmd.op     = OP_ALPHA_LD;
        state_next = S_AC_CLAMP;
      end
      S_AC_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_AC_NORM;
      end
      S_AC_NORM: begin
        // halve until den < 2^30, then clamp once more
        if (status.den_big) begin
          cmd.op = OP_HALVE;
        end else begin
          cmd.op     = OP_CLAMP;
          state_next = S_AC_MDD;
        end
      end
      S_AC_MDD: begin
        cmd.mul    = MUL_DD;
        state_next = S_AC_MNN;
      end
      S_AC_MNN: begin
        cmd.mul    = MUL_NN;
        cmd.op     = OP_TMP_SET;
        state_next = S_AC_RAD;
      end
      S_AC_RAD: begin
        cmd.op     = OP_RAD_SET;
        state_next = S_AC_SQ_GO;
      end
      S_AC_SQ_GO: begin
        cmd.sq_start = 1'b1;
        cmd.sq_sel   = SQ_RAD;
        state_next   = S_AC_SQ_WAIT;
      end
      S_AC_SQ_WAIT: begin
        if (status.sq_done) begin
          state_next = S_AC_CB_GO;
        end
      end
      S_AC_CB_GO: begin
        cmd.cb_start = 1'b1;
        cmd.cb_sel   = CB_ACOS;
        state_next   = S_AC_CB_WAIT;
      end
      S_AC_CB_WAIT: begin
        if (status.cb_done) begin
          if (second) begin
            cmd.op     = OP_ALPHA_SET;
            state_next = S_FINISH;
          end else begin
            cmd.op      = OP_GAMMA_SET;
            second_next = 1'b1;
            state_next  = S_AL_MUL;
          end
        end
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.op     = OP_OUT_LOAD;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/two_link_arm_inverse_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_unit
// Base / shoulder / elbow arm inverse kinematics by the law of cosines,
// producing whole-degree servo commands.
// ----------------------------------------------------------------------------
// One target item is worked on at a time. An unreachable target skips the
// roots and angles and returns its result (held commands, reachable low). A
// reachable target makes four passes through the shared bit-serial square
// root unit (two Q16 distances and two acos sines) and four through the
// shared CORDIC atan2 unit, runs its multiplies on the single 32x32
// multiplier, and takes up to 8 normalizing shifts in the shoulder acos.
// The result register holds a finished item while the next one is accepted
// and computed. Link lengths are written on write_enable, register_index 0
// for the upper link and 1 for the lower link; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_unit
  import tlaik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               target_valid,
  output logic               target_stall,
  input  logic [COORD_W-1:0] target_x,
  input  logic [COORD_W-1:0] target_y,
  input  logic [COORD_W-1:0] target_z,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               reachable,
  output logic [SVO_W-1:0]   base_command,
  output logic [SVO_W-1:0]   shoulder_command,
  output logic [SVO_W-1:0]   elbow_command,
  input  logic               write_enable,
  input  logic               register_index,
  input  logic [LINK_W-1:0]  write_data
);

  cmd_t    cmd;
  status_t status;

  tlaik_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .target_valid (target_valid),
    .target_stall (target_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  tlaik_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .target_x         (target_x),
    .target_y         (target_y),
    .target_z         (target_z),
    .write_enable     (write_enable),
    .register_index   (register_index),
    .write_data       (write_data),
    .reachable        (reachable),
    .base_command     (base_command),
    .shoulder_command (shoulder_command),
    .elbow_command    (elbow_command)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics unit testbench
// Walks a table of directed targets and link settings, then random targets under
// several link settings, with bursty input and a stalling result side. Typed rows
// are checked against the table, all others field by field against a bit-exact
// fixed-point model of the reach test, CORDIC atan2, square roots and servo rounding.
// ----------------------------------------------------------------------------
module testbench;
  import tlaik_pkg::*;

  localparam int NSTEPS = 16;
  localparam int PHASE_ITEMS = 260;
  localparam int SETTLE = 300;

  typedef enum logic {ROW_ITEM, ROW_LINKS} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        x;
    int        y;
    int        z;
    bit        typed;
    bit        reach;
    int        base;
    int        shoulder;
    int        elbow;
  } plan_row_t;

  typedef struct packed {
    logic             reach;
    logic [SVO_W-1:0] base;
    logic [SVO_W-1:0] shoulder;
    logic [SVO_W-1:0] elbow;
  } servo_set_t;

  localparam longint ATAN_Q16 [NSTEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic target_valid = 1'b0;
  logic target_stall;
  logic [COORD_W-1:0] target_x = '0;
  logic [COORD_W-1:0] target_y = '0;
  logic [COORD_W-1:0] target_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic reachable;
  logic [SVO_W-1:0] base_command;
  logic [SVO_W-1:0] shoulder_command;
  logic [SVO_W-1:0] elbow_command;
  logic write_enable = 1'b0;
  logic register_index = 1'b0;
  logic [LINK_W-1:0] write_data = '0;

  // model state
  longint upper_len = 5120;
  longint lower_len = 3840;
  logic [SVO_W-1:0] held_b = 8'd90;
  logic [SVO_W-1:0] held_s = 8'd90;
  logic [SVO_W-1:0] held_e = 8'd90;

  servo_set_t expected_cmds [$];
  servo_set_t typed_cmds [$];
  bit         typed_flag [$];
  int errors = 0;
  bit hold_req = 1'b0;

  two_link_arm_inverse_kinematics_unit i_dut (
    .clk(clk), .rst(rst),
    .target_valid(target_valid), .target_stall(target_stall),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .reachable(reachable), .base_command(base_command),
    .shoulder_command(shoulder_command), .elbow_command(elbow_command),
    .write_enable(write_enable), .register_index(register_index),
    .write_data(write_data)
  );

  always #4 clk = ~clk;

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------- fixed-point model ----------------
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint angle_q16(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic longint arc_cos_q16(longint num, longint den);
    longint unsigned e;
    if (num > den) num = den;
    if (num < -den) num = -den;
    while (den >= (64'sd1 <<< 30)) begin
      den = den >>> 1;
      num = num >>> 1;
    end
    if (num > den) num = den;
    if (num < -den) num = -den;
    e = root_floor(longint'(den * den - num * num));
    return angle_q16(longint'(e), num);
  endfunction

  function automatic int round_clamp(longint v, int hi);
    longint r;
    if (v >= 0) r = (v + 32768) >>> 16;
    else r = -((-v + 32768) >>> 16);
    if (r < 0) r = 0;
    if (r > hi) r = hi;
    return int'(r);
  endfunction

  function automatic servo_set_t solve_arm(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry,
                                           logic [COORD_W-1:0] rz);
    longint x, y, z, a, b, g2, r2, sm, df, r16, g16, base, beta, gamma, alpha;
    servo_set_t o;
    x = longint'($signed(rx));
    y = longint'($signed(ry));
    z = longint'($signed(rz));
    a = upper_len;
    b = lower_len;
    g2 = x * x + y * y;
    r2 = g2 + z * z;
    sm = a + b;
    df = a - b;
    if (r2 > sm * sm || r2 < df * df) begin
      o = '{1'b0, held_b, held_s, held_e};
      return o;
    end
    r16 = longint'(root_floor(longint'(r2) * 65536));
    g16 = longint'(root_floor(longint'(g2) * 65536));
    base = angle_q16(y * 65536, x * 65536);
    beta = angle_q16(z * 256, g16);
    gamma = arc_cos_q16((a * a + r2 - b * b) * 256, 2 * a * r16);
    alpha = arc_cos_q16(a * a + b * b - r2, 2 * a * b);
    held_b = SVO_W'(round_clamp(base + 90 * 65536, 180));
    held_s = SVO_W'(round_clamp(beta - gamma + 90 * 65536, 180));
    held_e = SVO_W'(round_clamp(180 * 65536 - alpha, 360) / 2);
    o = '{1'b1, held_b, held_s, held_e};
    return o;
  endfunction

  // ---------------- scoreboard ----------------
  always @(posedge clk) begin
    servo_set_t want, got;
    bit was_typed;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = '{reachable, base_command, shoulder_command, elbow_command};
        if (expected_cmds.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", got);
        end else begin
          want = expected_cmds.pop_front();
          was_typed = typed_flag.pop_front();
          if (was_typed) want = typed_cmds.pop_front();
          if (got.reach !== want.reach || got.base !== want.base ||
              got.shoulder !== want.shoulder || got.elbow !== want.elbow) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected r=%0d b=%0d s=%0d e=%0d got r=%0d b=%0d s=%0d e=%0d",
                       want.reach, want.base, want.shoulder, want.elbow,
                       got.reach, got.base, got.shoulder, got.elbow);
          end
        end
      end
      if (target_valid && !target_stall)
        expected_cmds.push_back(solve_arm(target_x, target_y, target_z));
      if (write_enable) begin
        if (register_index == REG_UPPER) upper_len = longint'(write_data);
        else lower_len = longint'(write_data);
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    int mode_left, mode, hold_left;
    bit s;
    bit hold_done;
    // one long hold per run
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 800;
      hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(2);
      mode_left = $urandom_range(200, 20);
    end
    mode_left--;
    case (mode)
      0: s = 1'b0;
      1: s = ($urandom_range(99) < 30);
      default: s = ($urandom_range(99) < 85);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end
    result_stall <= s;
  end

  // ---------------- sender ----------------
  int burst_left = 0;

  task automatic offer(int x, int y, int z);
    int gap;
    target_valid <= 1'b1;
    target_x <= COORD_W'(x);
    target_y <= COORD_W'(y);
    target_z <= COORD_W'(z);
    do @(posedge clk); while (target_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(25, 1);
      if (gap > 0) begin
        target_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(6);
    end
  endtask

  task automatic drain();
    target_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_links(int a, int b);
    drain();
    write_enable <= 1'b1;
    register_index <= REG_UPPER;
    write_data <= LINK_W'(a);
    @(posedge clk);
    register_index <= ~REG_UPPER;
    write_data <= LINK_W'(b);
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly targets inside the reach cube, the rest over the full range
  task automatic random_phase(int a, int b);
    int s, x, y, z;
    s = a + b;
    if (s > 32767) s = 32767;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(3) == 0 || s == 0) begin
        x = $urandom_range(65535) - 32768;
        y = $urandom_range(65535) - 32768;
        z = $urandom_range(65535) - 32768;
      end else begin
        x = $urandom_range(2 * s) - s;
        y = $urandom_range(2 * s) - s;
        z = $urandom_range(2 * s) - s;
      end
      offer(x, y, z);
    end
  endtask

  plan_row_t plan [] = '{
    '{ROW_ITEM, 0, 0, 0, 1, 0, 90, 90, 90},
    '{ROW_ITEM, 32767, 32767, 32767, 1, 0, 90, 90, 90},
    '{ROW_ITEM, -32768, -32768, -32768, 1, 0, 90, 90, 90},
    '{ROW_ITEM, 8960, 0, 0, 0, 0, 0, 0, 0},       // full stretch
    '{ROW_ITEM, 0, 0, 8960, 0, 0, 0, 0, 0},       // straight up, base atan2 of zeros
    '{ROW_ITEM, -5000, 3000, -2000, 0, 0, 0, 0, 0},
    '{ROW_ITEM, -5000, -3000, 1000, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, -6000, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 1280, 0, 0, 0, 0, 0, 0, 0},       // minimum reach
    '{ROW_ITEM, 1279, 0, 0, 0, 0, 0, 0, 0},       // just short of minimum reach, holds
    '{ROW_LINKS, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, 0, 1, 1, 90, 90, 90},       // r zero, zero links
    '{ROW_ITEM, 1, 0, 0, 1, 0, 90, 90, 90},
    '{ROW_LINKS, 16383, 16383, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 32767, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, -32768, -32768, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, -32768, 0, 0, 0, 0, 0},
    '{ROW_LINKS, 16383, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 16383, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 100, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_LINKS, 0, 16383, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, 16383, 0, 0, 0, 0, 0},      // zero upper link
    '{ROW_ITEM, 0, 9000, -13000, 0, 0, 0, 0, 0}
  };

  int cfg_a [] = '{5120, 16383, 1, 16383, 0, 0, 0};
  int cfg_b [] = '{3840, 16383, 1, 1, 9000, 0, 0};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LINKS) begin
        set_links(plan[i].x, plan[i].y);
      end else begin
        typed_flag.push_back(plan[i].typed);
        if (plan[i].typed)
          typed_cmds.push_back('{plan[i].reach, SVO_W'(plan[i].base),
                                 SVO_W'(plan[i].shoulder), SVO_W'(plan[i].elbow)});
        offer(plan[i].x, plan[i].y, plan[i].z);
      end
    end
    for (int p = 0; p < cfg_a.size(); p++) begin
      if (p >= 5) begin
        cfg_a[p] = $urandom_range(16383);
        cfg_b[p] = $urandom_range(16383);
      end
      set_links(cfg_a[p], cfg_b[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) typed_flag.push_back(1'b0);
      // keep offering through the long receiver hold
      if (p == 0) begin
        hold_req <= 1'b1;
        burst_left = PHASE_ITEMS;
      end
      random_phase(cfg_a[p], cfg_b[p]);
      hold_req <= 1'b0;
    end
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
